// ----- rtl/rsbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the retransmit slot backoff scheduler.
// No dependencies; every other file imports this package.
package rsbs_pkg;

  // Table size and derived widths.
  localparam int SLOTS       = 4;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 4;
  localparam int SEND_CNT_W  = $clog2(MAX_RESULTS + 1);

  // Backoff arithmetic widths.
  localparam int DIV_W  = 15;
  localparam int SPAN_W = 12;
  localparam logic [DIV_W-1:0] RAND_TOP = 15'd32767;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEP = 2'd3;

  // Register reset values.
  localparam logic [3:0] RETRY_LIMIT_RST  = 4'd10;
  localparam logic [7:0] FIRST_DELAY_RST  = 8'd5;
  localparam logic [7:0] RETRY_DELAY_RST  = 8'd15;
  localparam logic [7:0] BACKOFF_STEP_RST = 8'd128;

  // Action codes of an input word.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_REQ  = 2'd1;
  localparam logic [1:0] ACT_CONF = 2'd2;

  // Event codes of a result word.
  localparam logic [2:0] EV_SEND    = 3'd0;
  localparam logic [2:0] EV_ACCEPT  = 3'd1;
  localparam logic [2:0] EV_FULL    = 3'd2;
  localparam logic [2:0] EV_FREED   = 3'd3;
  localparam logic [2:0] EV_RESCHED = 3'd4;
  localparam logic [2:0] EV_NONE    = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] now_count;
    logic [3:0]  slot_index;
    logic [1:0]  tx_status;
    logic [14:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  out_slot;
    logic [15:0] due_count;
    logic        last;
  } out_word_t;

  // Builds one result word.
  function automatic out_word_t make_word(logic [2:0] kind, logic [3:0] slot,
                                          logic [15:0] due, logic fin);
    out_word_t w;
    w.event_kind = kind;
    w.out_slot   = slot;
    w.due_count  = due;
    w.last       = fin;
    return w;
  endfunction

endpackage

// ----- rtl/rsbs_div.sv -----
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rsbs_pkg for the operand width.
module rsbs_div import rsbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int STEP_W = $clog2(DIV_W);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = ~diff[DIV_W];
  end

  // Quotient bits shift into the dividend register as it empties.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (run_r) begin
        rem_r  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dvd_r  <= {dvd_r[DIV_W-2:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

// ----- rtl/retransmit_slot_backoff_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Top level of the retransmit slot scheduler: slot table, sequencer, config registers.
// Depends on rsbs_pkg and rsbs_div.
//
//  channel | ports                                 | handshake
//  --------+---------------------------------------+----------------------------------
//  input   | start, busy, in_word                  | word taken when start & !busy
//  result  | out_strobe, out_word                  | one cycle per word, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_index, data | write when cfg_valid & cfg_ready
//
// A tick walks the slot table one slot per cycle, then gives its final word.
// A request or a failed confirmation that reschedules runs two 15-step divisions
// in the shared divider, skipping both when the backoff step is zero; other
// requests and confirmations are answered straight from idle. Results are registered.
// Reset is synchronous, active low, clears the slot table and loads the config reset values.
// The receiver cannot stall, so results are never held back.
module retransmit_slot_backoff_scheduler_unit import rsbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_strobe,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_TICK_END, S_SPAN, S_DIV1, S_DIV2, S_FINISH
  } state_t;

  state_t                state_r;
  in_word_t              item_r;
  logic [SLOT_W-1:0]     idx_r;
  logic [SEND_CNT_W-1:0] sent_r;
  logic                  pend_v_r;
  logic [SLOT_W-1:0]     pend_slot_r;
  logic [3:0]            count_r;
  logic [7:0]            base_r;
  logic [DIV_W-1:0]      bo_r;
  logic                  is_req_r;
  logic                  div_go_r;
  logic [DIV_W-1:0]      div_dvd_r;
  logic [DIV_W-1:0]      div_dvs_r;
  logic                  out_strobe_r;
  out_word_t             out_word_r;

  logic [3:0]  retry_limit_r;
  logic [7:0]  first_delay_r;
  logic [7:0]  retry_delay_r;
  logic [7:0]  backoff_step_r;

  logic        busy_r [SLOTS];
  logic [3:0]  cnt_r  [SLOTS];
  logic [15:0] cd_r   [SLOTS];

  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] conf_idx;
  logic              conf_ok;
  logic [3:0]        conf_cnt;
  logic              resched;
  logic [SPAN_W-1:0] span;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [DIV_W-1:0]  q_adj;
  logic [15:0]       cur_cd;
  logic              tick_due;
  logic [15:0]       due;

  // Shared serial divider for both backoff divisions.
  rsbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Confirmation checks and the saturating attempt count.
  always_comb begin
    conf_idx = in_word.slot_index[SLOT_W-1:0];
    conf_ok  = (32'(in_word.slot_index) < SLOTS) && busy_r[conf_idx];
    conf_cnt = (cnt_r[conf_idx] == COUNT_MAX) ? COUNT_MAX : cnt_r[conf_idx] + 4'd1;
    resched  = in_word.tx_status[1] && (conf_cnt < retry_limit_r);
  end

  // Backoff span, divisor guard, tick compare and new schedule sum.
  always_comb begin
    span     = {4'b0, backoff_step_r} * {8'b0, count_r};
    q_adj    = (div_quot == '0) ? DIV_W'(1) : div_quot;
    cur_cd   = cd_r[idx_r];
    tick_due = cur_cd <= item_r.now_count;
    due      = item_r.now_count + {8'b0, base_r} + {1'b0, bo_r};
  end

  // Sequencer, slot table, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_strobe_r   <= 1'b0;
      div_go_r       <= 1'b0;
      pend_v_r       <= 1'b0;
      sent_r         <= '0;
      retry_limit_r  <= RETRY_LIMIT_RST;
      first_delay_r  <= FIRST_DELAY_RST;
      retry_delay_r  <= RETRY_DELAY_RST;
      backoff_step_r <= BACKOFF_STEP_RST;
      for (int i = 0; i < SLOTS; i++) begin
        busy_r[i] <= 1'b0;
        cnt_r[i]  <= '0;
        cd_r[i]   <= '0;
      end
    end else begin
      out_strobe_r <= 1'b0;
      div_go_r     <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_data[3:0];
          CFG_FIRST_DELAY:  first_delay_r  <= cfg_data;
          CFG_RETRY_DELAY:  retry_delay_r  <= cfg_data;
          CFG_BACKOFF_STEP: backoff_step_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r <= in_word;
            case (in_word.action)
              ACT_TICK: begin
                idx_r    <= '0;
                sent_r   <= '0;
                pend_v_r <= 1'b0;
                state_r  <= S_TICK;
              end
              ACT_REQ: begin
                if (free_found) begin
                  idx_r    <= free_slot;
                  count_r  <= 4'd1;
                  base_r   <= first_delay_r;
                  is_req_r <= 1'b1;
                  state_r  <= S_SPAN;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_word_r   <= make_word(EV_FULL, 4'd0, 16'd0, 1'b1);
                end
              end
              ACT_CONF: begin
                if (!conf_ok) begin
                  out_strobe_r <= 1'b1;
                  out_word_r   <= make_word(EV_NONE, in_word.slot_index, 16'd0, 1'b1);
                end else begin
                  cnt_r[conf_idx] <= conf_cnt;
                  if (resched) begin
                    idx_r    <= conf_idx;
                    count_r  <= conf_cnt;
                    base_r   <= retry_delay_r;
                    is_req_r <= 1'b0;
                    state_r  <= S_SPAN;
                  end else begin
                    busy_r[conf_idx] <= 1'b0;
                    cd_r[conf_idx]   <= '0;
                    out_strobe_r     <= 1'b1;
                    out_word_r <= make_word(EV_FREED, in_word.slot_index, 16'd0, 1'b1);
                  end
                end
              end
              default: begin
                out_strobe_r <= 1'b1;
                out_word_r   <= make_word(EV_NONE, 4'd0, 16'd0, 1'b1);
              end
            endcase
          end
        end

        // One slot per cycle; a send word is held back one find so that the
        // final one can carry the last flag.
        S_TICK: begin
          if (busy_r[idx_r] && (cur_cd != '0)) begin
            if (tick_due) begin
              if (sent_r < SEND_CNT_W'(MAX_RESULTS)) begin
                if (pend_v_r) begin
                  out_strobe_r <= 1'b1;
                  out_word_r   <= make_word(EV_SEND, 4'(pend_slot_r), 16'd0, 1'b0);
                end
                pend_slot_r <= idx_r;
                pend_v_r    <= 1'b1;
                sent_r      <= sent_r + 1'b1;
                cd_r[idx_r] <= '0;
              end else begin
                cd_r[idx_r] <= 16'd1;
              end
            end else begin
              cd_r[idx_r] <= cur_cd - item_r.now_count;
            end
          end
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            state_r <= S_TICK_END;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        S_TICK_END: begin
          out_strobe_r <= 1'b1;
          if (pend_v_r) begin
            out_word_r <= make_word(EV_SEND, 4'(pend_slot_r), 16'd0, 1'b1);
          end else begin
            out_word_r <= make_word(EV_NONE, 4'd0, 16'd0, 1'b1);
          end
          state_r <= S_IDLE;
        end

        // First division: 32767 / span, skipped when the span is zero.
        S_SPAN: begin
          if (span == '0) begin
            bo_r    <= '0;
            state_r <= S_FINISH;
          end else begin
            div_go_r  <= 1'b1;
            div_dvd_r <= RAND_TOP;
            div_dvs_r <= DIV_W'(span);
            state_r   <= S_DIV1;
          end
        end

        // Second division: random value over the first quotient.
        S_DIV1: begin
          if (div_done) begin
            div_go_r  <= 1'b1;
            div_dvd_r <= item_r.random_value;
            div_dvs_r <= q_adj;
            state_r   <= S_DIV2;
          end
        end

        S_DIV2: begin
          if (div_done) begin
            bo_r    <= div_quot;
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          cd_r[idx_r]  <= due;
          out_strobe_r <= 1'b1;
          if (is_req_r) begin
            busy_r[idx_r] <= 1'b1;
            cnt_r[idx_r]  <= 4'd1;
            out_word_r    <= make_word(EV_ACCEPT, 4'(idx_r), due, 1'b1);
          end else begin
            out_word_r    <= make_word(EV_RESCHED, 4'(idx_r), due, 1'b1);
          end
          state_r <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ----- rtl/rsbs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the scheduler's handshake and result words, with its bind.
// Depends on rsbs_pkg and the top level retransmit_slot_backoff_scheduler_unit.
module rsbs_checker import rsbs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input out_word_t             out_word
);

  // An accepted word either keeps the block busy or is answered at once.
  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted word neither started work nor gave a result");

  // A word that is not the final one of its item must have more to follow.
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.last |-> busy)
    else $error("non-final result word while the block is idle");

  // Only acceptances and reschedules carry a countdown.
  a_due_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_word.event_kind != EV_ACCEPT)
               && (out_word.event_kind != EV_RESCHED) |-> out_word.due_count == 16'd0)
    else $error("countdown reported on an event that carries none");

  // Send words only come from a tick, which always leaves the block busy first.
  a_send_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_word.event_kind == EV_SEND) |-> $past(busy))
    else $error("send word without a slot walk behind it");

endmodule

bind retransmit_slot_backoff_scheduler_unit rsbs_checker u_rsbs_checker (.*);
